// ----- src/qsbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsbs_pkg
// shared types and constants of the quicksort block sorter
// ----------------------------------------------------------------------------
package qsbs_pkg;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic last_out;
    logic overflowed;
  } out_item_t;

  // block descriptor handed from the loader to the sorter
  typedef struct packed {
    logic [IDX_W:0] count;
    logic dropped;
  } blk_t;
endpackage

// ----- src/qsbs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsbs_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface qsbs_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/qsbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsbs_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module qsbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- src/qsbs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsbs_front
// accepts items, counts the block, flags drops, hands a descriptor on last
// ----------------------------------------------------------------------------
module qsbs_front #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic clk,
  input  logic rst,
  qsbs_if.sink in_ch,
  input  logic grant,
  output logic we,
  output logic [qsbs_pkg::IDX_W-1:0] waddr,
  output logic [qsbs_pkg::VALUE_W-1:0] wdata,
  output logic blk_valid,
  output qsbs_pkg::blk_t blk,
  input  logic blk_ready
);
  import qsbs_pkg::*;
  logic [IDX_W:0] count;
  logic dropped;
  logic fire;
  logic room;

  assign in_ch.ready = grant && !blk_valid;
  assign fire = in_ch.valid && in_ch.ready;
  assign room = count < (IDX_W+1)'(MAX_ELEMENTS);
  assign we = fire && room;
  assign waddr = count[IDX_W-1:0];
  assign wdata = in_ch.data.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dropped <= 1'b0;
      blk_valid <= 1'b0;
    end else begin
      if (blk_valid && blk_ready) begin
        blk_valid <= 1'b0;
      end
      if (fire) begin
        if (in_ch.data.last_in) begin
          blk_valid <= 1'b1;
          blk.count <= room ? count + 1'b1 : count;
          blk.dropped <= dropped || !room;
          count <= '0;
          dropped <= 1'b0;
        end else if (room) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= (IDX_W+1)'(MAX_ELEMENTS)) else $error("count overrun");
  a_hold_blk: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_ready |=> blk_valid) else $error("block lost");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> !we) else $error("write while block pending");
endmodule

// ----- src/qsbs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsbs_back
// quicksort sequencer over the element ram with an explicit range stack,
// then emission of the sorted block
// ----------------------------------------------------------------------------
module qsbs_back (
  input  logic clk,
  input  logic rst,
  input  logic blk_valid,
  input  qsbs_pkg::blk_t blk,
  output logic blk_ready,
  output logic busy,
  output logic we,
  output logic [qsbs_pkg::IDX_W-1:0] addr,
  output logic [qsbs_pkg::VALUE_W-1:0] wdata,
  input  logic [qsbs_pkg::VALUE_W-1:0] rdata,
  qsbs_if.source out_ch
);
  import qsbs_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_POP = 16'h0002, S_PIV = 16'h0004, S_PIVW = 16'h0008,
    S_IRD = 16'h0010, S_IW = 16'h0020, S_JRD = 16'h0040, S_JW = 16'h0080,
    S_SWA = 16'h0100, S_SWB = 16'h0200, S_PLA = 16'h0400, S_PLB = 16'h0800,
    S_ERD = 16'h1000, S_EW = 16'h2000, S_EOUT = 16'h4000, S_STK = 16'h8000
  } state_t;

  state_t state;
  logic [IDX_W:0] count;
  logic dropped;
  logic [IDX_W-1:0] lo, hi, i, j, k;
  logic [VALUE_W-1:0] pivot, vi, vj;
  logic [IDX_W:0] sp;
  logic [2*IDX_W-1:0] stk_wdata, stk_rdata;
  logic stk_we;
  logic [IDX_W-1:0] stk_addr;
  logic le_piv;
  logic [IDX_W-1:0] p;

  assign le_piv = $signed(rdata) <= $signed(pivot);
  assign blk_ready = state == S_IDLE;
  assign busy = state != S_IDLE || blk_valid;
  assign p = j;

  qsbs_ram #(.WIDTH(2*IDX_W), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
  );

  // stack control: pushes in S_STK (two phases via k[0]), pop read
  always_comb begin
    stk_we = 1'b0;
    stk_wdata = '0;
    stk_addr = sp[IDX_W-1:0] - 1'b1;
    we = 1'b0;
    wdata = vj;
    addr = i;
    case (state)
      S_POP: stk_addr = sp[IDX_W-1:0] - 1'b1;
      S_PIV: addr = lo;
      S_IRD: addr = i;
      S_JRD: addr = j;
      S_SWA: begin
        we = 1'b1; addr = i; wdata = vj;
      end
      S_SWB: begin
        we = 1'b1; addr = j; wdata = vi;
      end
      S_PLA: begin
        we = 1'b1; addr = lo; wdata = vj;
      end
      S_PLB: begin
        we = 1'b1; addr = j; wdata = pivot;
      end
      S_STK: begin
        stk_addr = sp[IDX_W-1:0];
        if (!k[0]) begin
          stk_we = p > lo + 1'b1 || (p > lo && p - 1'b1 > lo);
          stk_wdata = {lo, p - 1'b1};
        end else begin
          stk_we = {1'b0, p} + 1'b1 < {1'b0, hi};
          stk_wdata = {p + 1'b1, hi};
        end
      end
      S_ERD: addr = k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      sp <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (blk_valid) begin
            count <= blk.count;
            dropped <= blk.dropped;
            k <= '0;
            if (blk.count >= (IDX_W+1)'(2)) begin
              lo <= '0;
              hi <= IDX_W'(blk.count - 1'b1);
              sp <= '0;
              state <= S_PIV;
            end else if (blk.count != '0) begin
              state <= S_ERD;
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            k <= '0;
            state <= S_ERD;
          end else begin
            sp <= sp - 1'b1;
            state <= S_PIVW;
          end
        end
        S_PIVW: begin
          lo <= stk_rdata[2*IDX_W-1:IDX_W];
          hi <= stk_rdata[IDX_W-1:0];
          state <= S_PIV;
        end
        S_PIV: begin
          i <= lo + 1'b1;
          j <= hi;
          state <= S_IW;
          k <= '1;
        end
        S_IW: begin
          if (k == '1) begin
            pivot <= rdata;
            k <= '0;
            state <= S_IRD;
          end else if (i < hi && le_piv) begin
            i <= i + 1'b1;
            state <= S_IRD;
          end else begin
            vi <= rdata;
            state <= S_JRD;
          end
        end
        S_IRD: state <= S_IW;
        S_JRD: state <= S_JW;
        S_JW: begin
          if (j > lo && !le_piv) begin
            j <= j - 1'b1;
            state <= S_JRD;
          end else begin
            vj <= rdata;
            state <= i >= j ? S_PLA : S_SWA;
          end
        end
        S_SWA: state <= S_SWB;
        S_SWB: state <= S_IRD;
        S_PLA: state <= S_PLB;
        S_PLB: begin
          k <= '0;
          state <= S_STK;
        end
        S_STK: begin
          if (stk_we) begin
            sp <= sp + 1'b1;
          end
          k <= k + 1'b1;
          if (k[0]) begin
            state <= S_POP;
          end
        end
        S_ERD: state <= S_EW;
        S_EW: begin
          out_ch.data.sorted_value <= rdata;
          out_ch.data.last_out <= {1'b0, k} + 1'b1 == count;
          out_ch.data.overflowed <= ({1'b0, k} + 1'b1 == count) && dropped;
          out_ch.valid <= 1'b1;
          state <= S_EOUT;
        end
        S_EOUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if ({1'b0, k} + 1'b1 == count) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (IDX_W+1)'(DEPTH)) else $error("stack overrun");
  a_valid_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_EOUT) else $error("stray output");
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_JW |-> j >= lo && j <= hi) else $error("scan out of range");
endmodule

// ----- src/quicksort_block_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_block_sorter
// flow: after the last item the block is handed to the sorter, which runs the
// partition scans, swaps and range steps on the one element ram port, then
// emits the sorted items one at a time as the receiver takes them
// throughput: one block at a time; items are taken one per cycle while loading
// reset: synchronous active high rst clears counts, stack pointer and handshakes
// ----------------------------------------------------------------------------
module quicksort_block_sorter #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input logic clk,
  input logic rst,
  qsbs_if.sink in_ch,
  qsbs_if.source out_ch
);
  import qsbs_pkg::*;

  logic f_we, b_we, busy, blk_valid, blk_ready;
  logic [IDX_W-1:0] f_addr, b_addr;
  logic [VALUE_W-1:0] f_wdata, b_wdata, rdata;
  blk_t blk;

  qsbs_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .grant(!busy),
    .we(f_we), .waddr(f_addr), .wdata(f_wdata),
    .blk_valid(blk_valid), .blk(blk), .blk_ready(blk_ready)
  );

  qsbs_back u_back (
    .clk(clk), .rst(rst), .blk_valid(blk_valid), .blk(blk), .blk_ready(blk_ready),
    .busy(busy), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(rdata),
    .out_ch(out_ch)
  );

  qsbs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(busy ? b_we : f_we), .addr(busy ? b_addr : f_addr),
    .wdata(busy ? b_wdata : f_wdata), .rdata(rdata)
  );
endmodule
